>>> src/mspm_pkg.sv
`timescale 1ns / 1ps
package mspm_pkg;

	localparam int SLOT_COUNT_DEF = 64;
	localparam logic [11:0] MAX_PAYLOAD_RST = 12'd1024;

	localparam logic [1:0] ST_FREE    = 2'd0;
	localparam logic [1:0] ST_FILLING = 2'd1;
	localparam logic [1:0] ST_READY   = 2'd2;
	localparam logic [2:0] CH_ANY     = 3'd7;
	localparam logic [1:0] DIR_TO_UART = 2'd1;
	localparam logic [1:0] DIR_TO_TCP  = 2'd2;
	localparam logic [2:0] CH_MAX      = 3'd4;

	localparam logic [2:0] OP_ALLOC   = 3'd0;
	localparam logic [2:0] OP_COMMIT  = 3'd1;
	localparam logic [2:0] OP_DEQUEUE = 3'd2;
	localparam logic [2:0] OP_RELEASE = 3'd3;
	localparam logic [2:0] OP_QUERY   = 3'd4;
	localparam logic [2:0] OP_CLRSTAT = 3'd5;

	localparam logic [0:0] REG_MAX_PAYLOAD = 1'd0;

	typedef struct packed {
		logic [2:0]  op;
		logic [5:0]  slot;
		logic [1:0]  direction;
		logic [2:0]  channel;
		logic [1:0]  match_status;
		logic [11:0] fill_length;
		logic [11:0] drain_position;
		logic [31:0] now_ms;
	} req_t;

	typedef struct packed {
		logic        ok;
		logic [5:0]  slot_out;
		logic [6:0]  free_slots;
		logic [6:0]  ready_to_uart;
		logic [6:0]  ready_to_tcp;
		logic [31:0] enqueued_total;
		logic [31:0] dequeued_total;
		logic [31:0] overflow_total;
		logic [11:0] found_length;
		logic [11:0] found_drain;
		logic [31:0] found_time;
		logic        doorbell;
	} rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN1,
		S_APPLY,
		S_SCAN2,
		S_DONE
	} state_t;

endpackage

>>> src/mspm_if.sv
`timescale 1ns / 1ps
interface mspm_req_if;
	import mspm_pkg::*;
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface mspm_rsp_if;
	import mspm_pkg::*;
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> src/message_slot_pool_manager.sv
`timescale 1ns / 1ps
// channel  role    payload
// req      sink    op, slot, direction, channel, match_status, lengths, now_ms
// rsp      source  ok, slot_out, counts, totals, found fields, doorbell
// apb      slave   max_payload at byte address 0
//
// one word runs a scan pass over the slot table (one slot per cycle through the
// shared compare unit), an update step, a count pass, and a result step. the
// slot table is one entry per cycle.
// arst_n frees all slots and clears counters; ready is low while a word is
// being worked and while a result waits to be taken.
module message_slot_pool_manager #(
	parameter int SLOT_COUNT = mspm_pkg::SLOT_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	mspm_req_if.sink    req,
	mspm_rsp_if.source  rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import mspm_pkg::*;

	localparam int IW = $clog2(SLOT_COUNT);
	localparam int CW = $clog2(SLOT_COUNT + 1);

	// slot table, status/dir/channel in flops (reset), rest in memory-like arrays
	logic [1:0]  st_q   [SLOT_COUNT];
	logic [1:0]  dir_q  [SLOT_COUNT];
	logic [2:0]  ch_q   [SLOT_COUNT];
	logic [11:0] len_q  [SLOT_COUNT];
	logic [11:0] drn_q  [SLOT_COUNT];
	logic [31:0] tim_q  [SLOT_COUNT];
	logic [30:0] seq_q  [SLOT_COUNT];
	// set once a commit has stored payload fields, so untouched entries read as zero
	logic [SLOT_COUNT-1:0] wr_q;

	logic [11:0] maxp_q;
	logic [IW-1:0] head_q;
	logic [31:0] enq_q, deq_q, ovf_q;
	state_t state_q, state_d;
	req_t req_q;
	logic [IW:0] idx_q;
	logic [CW-1:0] used_q, nfree_q, nuart_q, ntcp_q;
	logic best_v_q;
	logic [IW-1:0] best_q;
	logic [30:0] bseq_q;
	logic ok_q, bell_q;
	logic [IW-1:0] sout_q;
	logic [11:0] flen_q, fdrn_q;
	logic [31:0] ftim_q;
	logic rsp_v_q;
	logic [30:0] seq_rd_q;

	logic [IW-1:0] ix;
	logic [IW-1:0] cs;
	logic [IW-1:0] rd_ix;
	logic match;
	logic scan_last;

	assign pready = 1'b1;
	assign prdata = (paddr == {REG_MAX_PAYLOAD, 1'b0}) ? {20'd0, maxp_q} : 32'd0;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			maxp_q <= MAX_PAYLOAD_RST;
		end else if (psel && penable && pwrite && paddr == {REG_MAX_PAYLOAD, 1'b0}) begin
			maxp_q <= pwdata[11:0];
		end
	end

	assign ix = idx_q[IW-1:0];
	assign cs = req_q.slot[IW-1:0];
	assign scan_last = (idx_q == (IW+1)'(SLOT_COUNT - 1));
	// sequence read runs one slot ahead of the scan index
	assign rd_ix = (state_q == S_IDLE) ? '0 : IW'(idx_q + 1'b1);

	// shared compare unit: filter match for the current scan slot
	always_comb begin
		if (req_q.op == OP_ALLOC) begin
			match = (st_q[ix] == ST_READY);
		end else begin
			match = (st_q[ix] == req_q.match_status) && (dir_q[ix] == req_q.direction)
				&& (req_q.channel == CH_ANY || ch_q[ix] == req_q.channel);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (req.valid) state_d = S_SCAN1;
			S_SCAN1: if (scan_last) state_d = S_APPLY;
			S_APPLY: state_d = S_SCAN2;
			S_SCAN2: if (scan_last) state_d = S_DONE;
			S_DONE:  if (rsp.ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// handshake outputs
	always_comb begin
		req.ready = (state_q == S_IDLE);
		rsp.valid = rsp_v_q;
		rsp.data.ok = ok_q;
		rsp.data.slot_out = 6'(sout_q);
		rsp.data.free_slots = 7'(nfree_q);
		rsp.data.ready_to_uart = 7'(nuart_q);
		rsp.data.ready_to_tcp = 7'(ntcp_q);
		rsp.data.enqueued_total = enq_q;
		rsp.data.dequeued_total = deq_q;
		rsp.data.overflow_total = ovf_q;
		rsp.data.found_length = flen_q;
		rsp.data.found_drain = fdrn_q;
		rsp.data.found_time = ftim_q;
		rsp.data.doorbell = bell_q;
	end

	// control, counters and scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rsp_v_q <= 1'b0;
			head_q <= '0;
			enq_q <= '0;
			deq_q <= '0;
			ovf_q <= '0;
			idx_q <= '0;
			wr_q <= '0;
			for (int i = 0; i < SLOT_COUNT; i++) begin
				st_q[i] <= ST_FREE;
				dir_q[i] <= 2'd0;
				ch_q[i] <= 3'd0;
			end
		end else begin
			state_q <= state_d;
			unique case (state_q)
				S_IDLE: begin
					idx_q <= '0;
					used_q <= '0;
					best_v_q <= 1'b0;
					if (req.valid) req_q <= req.data;
				end
				S_SCAN1: begin
					idx_q <= scan_last ? '0 : idx_q + 1'b1;
					if (st_q[ix] != ST_FREE) used_q <= used_q + 1'b1;
					if (match && (!best_v_q || seq_rd_q < bseq_q)) begin
						best_v_q <= 1'b1;
						best_q <= ix;
						bseq_q <= seq_rd_q;
					end
				end
				S_APPLY: begin
					ok_q <= 1'b0;
					bell_q <= 1'b0;
					sout_q <= '0;
					flen_q <= '0;
					fdrn_q <= '0;
					ftim_q <= '0;
					nfree_q <= '0;
					nuart_q <= '0;
					ntcp_q <= '0;
					unique case (req_q.op)
						OP_ALLOC: begin
							ok_q <= 1'b1;
							if (used_q == CW'(SLOT_COUNT) && best_v_q) begin
								sout_q <= best_q;
								st_q[best_q] <= ST_FILLING;
								dir_q[best_q] <= req_q.direction;
								ch_q[best_q] <= req_q.channel;
								ovf_q <= ovf_q + 1'b1;
							end else begin
								sout_q <= head_q;
								st_q[head_q] <= ST_FILLING;
								dir_q[head_q] <= req_q.direction;
								ch_q[head_q] <= req_q.channel;
								head_q <= (head_q == IW'(SLOT_COUNT - 1)) ? '0 : head_q + 1'b1;
							end
						end
						OP_COMMIT: begin
							if (32'(req_q.slot) < SLOT_COUNT && st_q[cs] == ST_FILLING
								&& req_q.fill_length <= maxp_q
								&& req_q.drain_position <= maxp_q
								&& (dir_q[cs] == DIR_TO_UART || dir_q[cs] == DIR_TO_TCP)
								&& ch_q[cs] <= CH_MAX) begin
								st_q[cs] <= ST_READY;
								wr_q[cs] <= 1'b1;
								enq_q <= enq_q + 1'b1;
								ok_q <= 1'b1;
								bell_q <= 1'b1;
							end
						end
						OP_DEQUEUE: begin
							if (best_v_q) begin
								deq_q <= deq_q + 1'b1;
								ok_q <= 1'b1;
								sout_q <= best_q;
								flen_q <= wr_q[best_q] ? len_q[best_q] : '0;
								fdrn_q <= wr_q[best_q] ? drn_q[best_q] : '0;
								ftim_q <= wr_q[best_q] ? tim_q[best_q] : '0;
							end
						end
						OP_RELEASE: begin
							if (32'(req_q.slot) < SLOT_COUNT && st_q[cs] == ST_READY) begin
								st_q[cs] <= ST_FREE;
								dir_q[cs] <= 2'd0;
								ch_q[cs] <= CH_ANY;
								ok_q <= 1'b1;
							end
						end
						OP_QUERY: ok_q <= 1'b1;
						OP_CLRSTAT: begin
							enq_q <= '0;
							deq_q <= '0;
							ovf_q <= '0;
							ok_q <= 1'b1;
						end
						default: ok_q <= 1'b0;
					endcase
				end
				S_SCAN2: begin
					idx_q <= scan_last ? '0 : idx_q + 1'b1;
					if (st_q[ix] == ST_FREE) nfree_q <= nfree_q + 1'b1;
					else if (st_q[ix] == ST_READY && dir_q[ix] == DIR_TO_UART)
						nuart_q <= nuart_q + 1'b1;
					else if (st_q[ix] == ST_READY && dir_q[ix] == DIR_TO_TCP)
						ntcp_q <= ntcp_q + 1'b1;
					if (scan_last) rsp_v_q <= 1'b1;
				end
				S_DONE: begin
					if (rsp.ready) rsp_v_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// payload fields of the slot table, one entry written per word
	always_ff @(posedge clk) begin
		seq_rd_q <= wr_q[rd_ix] ? seq_q[rd_ix] : '0;
		if (state_q == S_APPLY) begin
			if (req_q.op == OP_ALLOC) begin
				if (used_q == CW'(SLOT_COUNT) && best_v_q) begin
					len_q[best_q] <= '0;
					drn_q[best_q] <= '0;
					tim_q[best_q] <= '0;
					seq_q[best_q] <= '0;
				end else begin
					len_q[head_q] <= '0;
					drn_q[head_q] <= '0;
					tim_q[head_q] <= '0;
					seq_q[head_q] <= '0;
				end
			end else if (req_q.op == OP_COMMIT && 32'(req_q.slot) < SLOT_COUNT
				&& st_q[cs] == ST_FILLING && req_q.fill_length <= maxp_q
				&& req_q.drain_position <= maxp_q
				&& (dir_q[cs] == DIR_TO_UART || dir_q[cs] == DIR_TO_TCP)
				&& ch_q[cs] <= CH_MAX) begin
				len_q[cs] <= req_q.fill_length;
				drn_q[cs] <= req_q.drain_position;
				tim_q[cs] <= req_q.now_ms;
				seq_q[cs] <= enq_q[30:0];
			end else if (req_q.op == OP_RELEASE && 32'(req_q.slot) < SLOT_COUNT
				&& st_q[cs] == ST_READY) begin
				len_q[cs] <= '0;
				drn_q[cs] <= '0;
				tim_q[cs] <= '0;
				seq_q[cs] <= '0;
			end
		end
	end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import mspm_pkg::*;

	localparam int NSLOT = 64;
	localparam int WORD_CYCLES = 2 * NSLOT + 3;
	localparam longint CYCLE_LIMIT = 2_000_000;

	// slot pool predictor and store of expected result words
	class pool_scoreboard;
		bit [1:0]  st [NSLOT];
		bit [1:0]  dir [NSLOT];
		bit [2:0]  chn [NSLOT];
		bit [11:0] len [NSLOT];
		bit [11:0] drn [NSLOT];
		bit [31:0] stamp [NSLOT];
		bit [30:0] seqn [NSLOT];
		bit [5:0]  head;
		bit [31:0] enq_cnt, deq_cnt, ovf_cnt;
		bit [11:0] max_pay;
		rsp_t      expected_words[$];
		int        errors;

		function new();
			foreach (st[i]) begin
				st[i] = ST_FREE; dir[i] = 0; chn[i] = 0; len[i] = 0;
				drn[i] = 0; stamp[i] = 0; seqn[i] = 0;
			end
			head = 0; enq_cnt = 0; deq_cnt = 0; ovf_cnt = 0;
			max_pay = MAX_PAYLOAD_RST;
			errors = 0;
		endfunction

		function void clear_slot(int i);
			dir[i] = 0; chn[i] = CH_ANY; len[i] = 0; drn[i] = 0;
			stamp[i] = 0; seqn[i] = 0;
		endfunction

		// oldest matching slot, NSLOT when none
		function int oldest(bit [1:0] s, bit chk, bit [1:0] d, bit [2:0] c);
			int best;
			bit [31:0] best_seq;
			best = NSLOT;
			best_seq = '1;
			for (int i = 0; i < NSLOT; i++) begin
				if (st[i] != s) continue;
				if (chk && dir[i] != d) continue;
				if (chk && c != CH_ANY && chn[i] != c) continue;
				if ({1'b0, seqn[i]} < best_seq) begin
					best = i;
					best_seq = {1'b0, seqn[i]};
				end
			end
			return best;
		endfunction

		// random slot index in the given status, -1 when none
		function int pick(bit [1:0] s);
			int hits[$];
			for (int i = 0; i < NSLOT; i++)
				if (st[i] == s) hits.push_back(i);
			if (hits.size() == 0) return -1;
			return hits[$urandom_range(hits.size() - 1)];
		endfunction

		function void note(req_t w);
			rsp_t r;
			int used, p, f;
			r = '0;
			case (w.op)
				OP_ALLOC: begin
					used = 0;
					foreach (st[i]) if (st[i] != ST_FREE) used++;
					p = NSLOT;
					if (used >= NSLOT) p = oldest(ST_READY, 0, 0, 0);
					if (p < NSLOT) begin
						ovf_cnt++;
					end else begin
						p = head;
						head = head + 6'd1;
					end
					clear_slot(p);
					st[p] = ST_FILLING; dir[p] = w.direction; chn[p] = w.channel;
					r.ok = 1;
					r.slot_out = p[5:0];
				end
				OP_COMMIT: begin
					p = w.slot;
					if (st[p] == ST_FILLING && w.fill_length <= max_pay &&
							w.drain_position <= max_pay &&
							(dir[p] == DIR_TO_UART || dir[p] == DIR_TO_TCP) &&
							chn[p] <= CH_MAX) begin
						len[p] = w.fill_length; drn[p] = w.drain_position;
						stamp[p] = w.now_ms; seqn[p] = enq_cnt[30:0];
						st[p] = ST_READY;
						enq_cnt++;
						r.ok = 1;
						r.doorbell = 1;
					end
				end
				OP_DEQUEUE: begin
					f = oldest(w.match_status, 1, w.direction, w.channel);
					if (f < NSLOT) begin
						deq_cnt++;
						r.ok = 1;
						r.slot_out = f[5:0];
						r.found_length = len[f];
						r.found_drain = drn[f];
						r.found_time = stamp[f];
					end
				end
				OP_RELEASE: begin
					p = w.slot;
					if (st[p] == ST_READY) begin
						st[p] = ST_FREE;
						clear_slot(p);
						r.ok = 1;
					end
				end
				OP_QUERY: r.ok = 1;
				OP_CLRSTAT: begin
					enq_cnt = 0; deq_cnt = 0; ovf_cnt = 0;
					r.ok = 1;
				end
				default: ;
			endcase
			// occupancy after the operation
			foreach (st[i]) begin
				if (st[i] == ST_FREE) r.free_slots++;
				else if (st[i] == ST_READY) begin
					if (dir[i] == DIR_TO_UART) r.ready_to_uart++;
					else if (dir[i] == DIR_TO_TCP) r.ready_to_tcp++;
				end
			end
			r.enqueued_total = enq_cnt;
			r.dequeued_total = deq_cnt;
			r.overflow_total = ovf_cnt;
			expected_words.push_back(r);
		endfunction

		task report(string what, longint got, longint want);
			$display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
			errors++;
		endtask

		task cmp(string what, longint got, longint want);
			if (got != want) report(what, got, want);
		endtask

		task check(rsp_t g);
			rsp_t e;
			if (expected_words.size() == 0) begin
				report("unexpected result word", g.slot_out, 0);
				return;
			end
			e = expected_words.pop_front();
			cmp("ok", g.ok, e.ok);
			cmp("slot_out", g.slot_out, e.slot_out);
			cmp("free_slots", g.free_slots, e.free_slots);
			cmp("ready_to_uart", g.ready_to_uart, e.ready_to_uart);
			cmp("ready_to_tcp", g.ready_to_tcp, e.ready_to_tcp);
			cmp("enqueued_total", g.enqueued_total, e.enqueued_total);
			cmp("dequeued_total", g.dequeued_total, e.dequeued_total);
			cmp("overflow_total", g.overflow_total, e.overflow_total);
			cmp("found_length", g.found_length, e.found_length);
			cmp("found_drain", g.found_drain, e.found_drain);
			cmp("found_time", g.found_time, e.found_time);
			cmp("doorbell", g.doorbell, e.doorbell);
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [1:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	mspm_req_if req ();
	mspm_rsp_if rsp ();

	message_slot_pool_manager uut (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	pool_scoreboard sb = new();
	int     send_idle_pct;
	int     recv_idle_pct;
	longint cycles;

	// clock
	initial clk = 0;
	always #5 clk = ~clk;

	// run limit
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// receiver stalls
	always @(negedge clk) begin
		rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// watch both channels
	always @(posedge clk) begin
		if (arst_n && req.valid && req.ready) sb.note(req.data);
		if (arst_n && rsp.valid && rsp.ready) sb.check(rsp.data);
	end

	task send_word(req_t w);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 0;
			@(negedge clk);
		end
		req.valid <= 1;
		req.data <= w;
		do @(posedge clk); while (!req.ready);
		@(negedge clk);
		req.valid <= 0;
	endtask

	task wait_drained();
		while (sb.expected_words.size() != 0) @(posedge clk);
	endtask

	task write_max_payload(bit [11:0] v);
		wait_drained();
		repeat (4) @(posedge clk);
		@(negedge clk);
		req.valid <= 0;
		psel <= 1; pwrite <= 1; penable <= 0;
		paddr <= 2'(REG_MAX_PAYLOAD * 4);
		pwdata <= {20'd0, v};
		@(negedge clk);
		penable <= 1;
		do @(posedge clk); while (!pready);
		sb.max_pay = v;
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	function req_t mk(bit [2:0] op, bit [5:0] slot, bit [1:0] d, bit [2:0] c,
			bit [1:0] ms, bit [11:0] fl, bit [11:0] dp, bit [31:0] now);
		req_t w;
		w.op = op; w.slot = slot; w.direction = d; w.channel = c;
		w.match_status = ms; w.fill_length = fl; w.drain_position = dp;
		w.now_ms = now;
		return w;
	endfunction

	// mostly well-formed words aimed at live slots, some noise
	function req_t random_word();
		req_t w;
		int r, p;
		w = mk(3'($urandom), 6'($urandom), 2'($urandom), 3'($urandom), 2'($urandom),
			12'($urandom), 12'($urandom), $urandom);
		if ($urandom_range(99) < 85) begin
			w.direction = 2'($urandom_range(DIR_TO_UART, DIR_TO_TCP));
			w.channel = 3'($urandom_range(0, CH_MAX));
		end
		r = $urandom_range(99);
		if (r < 28) begin
			w.op = OP_ALLOC;
		end else if (r < 53) begin
			w.op = OP_COMMIT;
			p = sb.pick(ST_FILLING);
			if (p >= 0 && $urandom_range(99) < 85) w.slot = 6'(p);
			if ($urandom_range(99) < 85) begin
				w.fill_length = 12'($urandom_range(0, sb.max_pay));
				w.drain_position = 12'($urandom_range(0, sb.max_pay));
			end
		end else if (r < 70) begin
			w.op = OP_DEQUEUE;
			if ($urandom_range(99) < 80) w.match_status = ST_READY;
			if ($urandom_range(99) < 40) w.channel = CH_ANY;
		end else if (r < 85) begin
			w.op = OP_RELEASE;
			p = sb.pick(ST_READY);
			if (p >= 0 && $urandom_range(99) < 85) w.slot = 6'(p);
		end else if (r < 92) begin
			w.op = OP_QUERY;
		end else if (r < 95) begin
			w.op = OP_CLRSTAT;
		end else begin
			w.op = 3'($urandom_range(6, 7));
		end
		return w;
	endfunction

	task run_phase(int n, bit pause_mid);
		req_t w;
		for (int k = 0; k < n; k++) begin
			// a burst of allocates at the start fills the pool with filling slots
			if (k == 0) begin
				for (int b = 0; b < 70; b++) begin
					w = random_word();
					w.op = OP_ALLOC;
					send_word(w);
				end
			end
			if (pause_mid && k == n / 2) wait_drained();
			send_word(random_word());
		end
	endtask

	initial begin
		arst_n = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		req.valid = 0; req.data = '0;
		rsp.ready = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		// directed: every op, limits, refusals and no-match searches
		send_word(mk(OP_QUERY, 0, 0, 0, 0, 0, 0, 0));
		send_word(mk(OP_CLRSTAT, 63, 3, 7, 3, 12'hfff, 12'hfff, '1));
		send_word(mk(3'd6, 0, 0, 0, 0, 0, 0, 0));
		send_word(mk(3'd7, 63, 3, 7, 3, 12'hfff, 12'hfff, '1));
		send_word(mk(OP_ALLOC, 0, DIR_TO_UART, 0, 0, 0, 0, 0));
		send_word(mk(OP_ALLOC, 0, DIR_TO_TCP, CH_MAX, 0, 0, 0, 0));
		send_word(mk(OP_ALLOC, 0, 0, CH_ANY, 0, 0, 0, 0));
		send_word(mk(OP_ALLOC, 0, 3, 5, 0, 0, 0, 0));
		send_word(mk(OP_COMMIT, 0, 0, 0, 0, 1024, 1024, '1));
		send_word(mk(OP_COMMIT, 1, 0, 0, 0, 1025, 0, 5));
		send_word(mk(OP_COMMIT, 1, 0, 0, 0, 0, 1025, 5));
		send_word(mk(OP_COMMIT, 1, 0, 0, 0, 0, 0, 0));
		send_word(mk(OP_COMMIT, 2, 0, 0, 0, 0, 0, 1));
		send_word(mk(OP_COMMIT, 3, 0, 0, 0, 0, 0, 1));
		send_word(mk(OP_COMMIT, 63, 0, 0, 0, 0, 0, 1));
		send_word(mk(OP_DEQUEUE, 0, DIR_TO_UART, CH_ANY, ST_READY, 0, 0, 0));
		send_word(mk(OP_DEQUEUE, 0, DIR_TO_TCP, CH_MAX, ST_READY, 0, 0, 0));
		send_word(mk(OP_DEQUEUE, 0, DIR_TO_UART, 3, ST_READY, 0, 0, 0));
		send_word(mk(OP_DEQUEUE, 0, 0, CH_ANY, ST_FILLING, 0, 0, 0));
		send_word(mk(OP_DEQUEUE, 0, 0, 0, ST_FREE, 0, 0, 0));
		send_word(mk(OP_DEQUEUE, 0, 0, 0, 3, 0, 0, 0));
		send_word(mk(OP_RELEASE, 0, 0, 0, 0, 0, 0, 0));
		send_word(mk(OP_RELEASE, 0, 0, 0, 0, 0, 0, 0));
		send_word(mk(OP_RELEASE, 2, 0, 0, 0, 0, 0, 0));

		// random phases under different limits and idling
		write_max_payload(12'd0);
		send_idle_pct = 27; recv_idle_pct = 56;
		run_phase(320, 1);
		write_max_payload(12'hfff);
		send_idle_pct = 56; recv_idle_pct = 27;
		run_phase(320, 0);
		write_max_payload(12'($urandom_range(1, 4094)));
		send_idle_pct = 0; recv_idle_pct = 0;
		run_phase(320, 0);

		@(negedge clk);
		req.valid <= 0;
		wait_drained();
		repeat (WORD_CYCLES + 10) @(posedge clk);
		if (sb.errors == 0 && sb.expected_words.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
